// ----- src/spfm_pkg.sv -----
`default_nettype none

package spfm_pkg;

    localparam int FRAMES         = 16;
    localparam int FRAME_W        = 4;
    localparam int PAGES_PER_PROC = 32;
    localparam int PAGE_W         = 5;
    localparam int ASID_W         = 4;
    localparam int VPN_W          = 20;
    localparam int TEXT_W         = 18;
    localparam int SECTOR_W       = 8;
    localparam int PAGE_SHIFT     = 12;

    typedef enum logic [1:0] {
        STATUS_INSTALLED  = 2'd0,
        STATUS_TERMINATED = 2'd1,
        STATUS_RELEASED   = 2'd2
    } status_t;

    typedef enum logic {
        CMD_FAULT   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef struct packed {
        status_t             kind;
        logic [ASID_W-1:0]   asid;
        logic [PAGE_W-1:0]   page;
        logic                writable;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [FRAME_W-1:0]    frame;
        logic                  evicted;
        logic [ASID_W-1:0]     victim_asid;
        logic [PAGE_W-1:0]     victim_page;
        logic                  writeback;
        logic [SECTOR_W-1:0]   write_sector;
        logic [SECTOR_W-1:0]   read_sector;
        logic                  writable;
    } rsp_t;

    function automatic logic [SECTOR_W-1:0] sector_of(
        input logic [ASID_W-1:0] asid,
        input logic [PAGE_W-1:0] page
    );
        logic [SECTOR_W-1:0] base;
        base = SECTOR_W'(asid) - SECTOR_W'(1);
        return SECTOR_W'(base * SECTOR_W'(PAGES_PER_PROC)) + SECTOR_W'(page);
    endfunction

endpackage

`default_nettype wire

// ----- src/spfm_decode.sv -----
`default_nettype none

module spfm_decode #(
    parameter int MAX_PROCS     = 8,
    parameter int USER_BASE_VPN = 524288,
    parameter int STACK_VPN     = 786431
) (
    input  wire logic                          cmd,
    input  wire logic [spfm_pkg::ASID_W-1:0]   asid,
    input  wire logic [spfm_pkg::VPN_W-1:0]    fault_vpn,
    input  wire logic                          modify_fault,
    input  wire logic [spfm_pkg::TEXT_W-1:0]   text_bytes,
    output spfm_pkg::req_t                     req
);

    localparam logic [spfm_pkg::VPN_W:0] USER_LO = (spfm_pkg::VPN_W + 1)'(USER_BASE_VPN);
    localparam logic [spfm_pkg::VPN_W:0] USER_HI =
        (spfm_pkg::VPN_W + 1)'(USER_BASE_VPN + spfm_pkg::PAGES_PER_PROC - 2);
    localparam logic [spfm_pkg::VPN_W-1:0] STACK = spfm_pkg::VPN_W'(STACK_VPN);
    localparam logic [spfm_pkg::VPN_W-1:0] USER_BASE = spfm_pkg::VPN_W'(USER_BASE_VPN);
    localparam logic [spfm_pkg::ASID_W-1:0] ASID_MAX = spfm_pkg::ASID_W'(MAX_PROCS);

    logic [spfm_pkg::VPN_W:0]                       vpn_ext;
    logic                                           in_user;
    logic                                           is_stack;
    logic                                           asid_ok;
    logic [spfm_pkg::PAGE_W-1:0]                    page;
    logic [spfm_pkg::PAGE_W+spfm_pkg::PAGE_SHIFT-1:0] page_base;

    assign vpn_ext   = {1'b0, fault_vpn};
    assign in_user   = (vpn_ext >= USER_LO) && (vpn_ext <= USER_HI);
    assign is_stack  = (fault_vpn == STACK);
    assign asid_ok   = (asid != '0) && (asid <= ASID_MAX);
    assign page      = in_user ? spfm_pkg::PAGE_W'(fault_vpn - USER_BASE)
                               : spfm_pkg::PAGE_W'(spfm_pkg::PAGES_PER_PROC - 1);
    assign page_base = {page, {spfm_pkg::PAGE_SHIFT{1'b0}}};

    always_comb
    begin
        req.asid     = asid;
        req.page     = page;
        req.writable = !(spfm_pkg::TEXT_W'(page_base) < text_bytes);
        if (spfm_pkg::cmd_t'(cmd) == spfm_pkg::CMD_RELEASE)
        begin
            req.kind = spfm_pkg::STATUS_RELEASED;
        end
        else if (modify_fault || !asid_ok || !(in_user || is_stack))
        begin
            req.kind = spfm_pkg::STATUS_TERMINATED;
        end
        else
        begin
            req.kind = spfm_pkg::STATUS_INSTALLED;
        end
    end

endmodule

`default_nettype wire

// ----- src/spfm_table.sv -----
`default_nettype none

module spfm_table (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          apply,
    input  wire spfm_pkg::req_t req,
    output spfm_pkg::rsp_t     rsp
);

    logic [spfm_pkg::ASID_W-1:0]  owner_reg [spfm_pkg::FRAMES];
    logic [spfm_pkg::PAGE_W-1:0]  page_reg  [spfm_pkg::FRAMES];
    logic                         dirty_reg [spfm_pkg::FRAMES];
    logic [spfm_pkg::FRAME_W-1:0] fifo_reg;
    logic [spfm_pkg::FRAME_W-1:0] fifo_next;

    logic                         found;
    logic [spfm_pkg::FRAME_W-1:0] lowest_free;
    logic [spfm_pkg::FRAME_W-1:0] victim;
    logic                         occupied;

    always_comb
    begin
        found       = 1'b0;
        lowest_free = '0;
        for (int i = spfm_pkg::FRAMES - 1; i >= 0; i--)
        begin
            if (owner_reg[i] == '0)
            begin
                found       = 1'b1;
                lowest_free = spfm_pkg::FRAME_W'(i);
            end
        end
    end

    always_comb
    begin
        if (found)
        begin
            victim = lowest_free;
        end
        else if (fifo_reg == spfm_pkg::FRAME_W'(spfm_pkg::FRAMES - 1))
        begin
            victim = '0;
        end
        else
        begin
            victim = fifo_reg + spfm_pkg::FRAME_W'(1);
        end
    end

    assign occupied  = (owner_reg[victim] != '0);
    assign fifo_next = victim;

    always_comb
    begin
        rsp        = '0;
        rsp.status = req.kind;
        if (req.kind == spfm_pkg::STATUS_INSTALLED)
        begin
            rsp.frame       = victim;
            rsp.read_sector = spfm_pkg::sector_of(req.asid, req.page);
            rsp.writable    = req.writable;
            if (occupied)
            begin
                rsp.evicted     = 1'b1;
                rsp.victim_asid = owner_reg[victim];
                rsp.victim_page = page_reg[victim];
                if (dirty_reg[victim])
                begin
                    rsp.writeback    = 1'b1;
                    rsp.write_sector = spfm_pkg::sector_of(owner_reg[victim],
                                                           page_reg[victim]);
                end
            end
        end
    end

    // Installing a page rewrites one frame; terminating or releasing clears every
    // frame that the address space owns.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_reg <= '0;
            for (int i = 0; i < spfm_pkg::FRAMES; i++)
            begin
                owner_reg[i] <= '0;
                page_reg[i]  <= '0;
                dirty_reg[i] <= 1'b0;
            end
        end
        else if (apply)
        begin
            case (req.kind)
                spfm_pkg::STATUS_INSTALLED:
                begin
                    fifo_reg          <= fifo_next;
                    owner_reg[victim] <= req.asid;
                    page_reg[victim]  <= req.page;
                    dirty_reg[victim] <= req.writable;
                end
                spfm_pkg::STATUS_TERMINATED, spfm_pkg::STATUS_RELEASED:
                begin
                    for (int i = 0; i < spfm_pkg::FRAMES; i++)
                    begin
                        if (owner_reg[i] == req.asid)
                        begin
                            owner_reg[i] <= '0;
                            page_reg[i]  <= '0;
                            dirty_reg[i] <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    fifo_reg <= fifo_reg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/swap_pool_frame_manager.sv -----
`default_nettype none

// Channel    Handshake                Payload
// request    req_valid / req_ready    cmd, asid, fault_vpn, modify_fault, text_bytes
// response   rsp_valid / rsp_ready    status, frame, evicted, victim_asid, victim_page,
//                                     writeback, write_sector, read_sector, writable
//
// Each transaction passes through an input register and then a result register, which
// offers its response; one transaction is taken every cycle while the response side
// keeps up. The frame table updates in the same cycle that a transaction moves into
// the result register, so the next one sees it.
// A stalled response holds the input register, and request ready then drops.
// Reset empties the frame table and both registers at once.
module swap_pool_frame_manager #(
    parameter int MAX_PROCS     = 8,
    parameter int USER_BASE_VPN = 524288,
    parameter int STACK_VPN     = 786431
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire logic                            cmd,
    input  wire logic [spfm_pkg::ASID_W-1:0]     asid,
    input  wire logic [spfm_pkg::VPN_W-1:0]      fault_vpn,
    input  wire logic                            modify_fault,
    input  wire logic [spfm_pkg::TEXT_W-1:0]     text_bytes,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output logic [1:0]                           status,
    output logic [spfm_pkg::FRAME_W-1:0]         frame,
    output logic                                 evicted,
    output logic [spfm_pkg::ASID_W-1:0]          victim_asid,
    output logic [spfm_pkg::PAGE_W-1:0]          victim_page,
    output logic                                 writeback,
    output logic [spfm_pkg::SECTOR_W-1:0]        write_sector,
    output logic [spfm_pkg::SECTOR_W-1:0]        read_sector,
    output logic                                 writable
);

    logic                            in_valid_reg;
    logic                            in_valid_next;
    logic                            cmd_reg;
    logic [spfm_pkg::ASID_W-1:0]     asid_reg;
    logic [spfm_pkg::VPN_W-1:0]      vpn_reg;
    logic                            modify_reg;
    logic [spfm_pkg::TEXT_W-1:0]     text_reg;

    logic                            rsp_valid_reg;
    logic                            rsp_valid_next;
    spfm_pkg::rsp_t                  rsp_reg;
    spfm_pkg::rsp_t                  rsp_next;

    spfm_pkg::req_t                  req;
    logic                            advance;
    logic                            accept;

    assign advance        = in_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready      = !in_valid_reg || advance;
    assign accept         = req_valid && req_ready;
    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && !rsp_ready);

    spfm_decode #(
        .MAX_PROCS     (MAX_PROCS),
        .USER_BASE_VPN (USER_BASE_VPN),
        .STACK_VPN     (STACK_VPN)
    ) u_decode (
        .cmd          (cmd_reg),
        .asid         (asid_reg),
        .fault_vpn    (vpn_reg),
        .modify_fault (modify_reg),
        .text_bytes   (text_reg),
        .req          (req)
    );

    spfm_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .apply (advance),
        .req   (req),
        .rsp   (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            asid_reg   <= asid;
            vpn_reg    <= fault_vpn;
            modify_reg <= modify_fault;
            text_reg   <= text_bytes;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_reg.status;
    assign frame        = rsp_reg.frame;
    assign evicted      = rsp_reg.evicted;
    assign victim_asid  = rsp_reg.victim_asid;
    assign victim_page  = rsp_reg.victim_page;
    assign writeback    = rsp_reg.writeback;
    assign write_sector = rsp_reg.write_sector;
    assign read_sector  = rsp_reg.read_sector;
    assign writable     = rsp_reg.writable;

endmodule

`default_nettype wire
